### rtl/nnis_pkg.sv
// Shared types and constants of the nearest-neighbour image scaler.
`default_nettype none

package nnis_pkg;

    localparam int DIM_W           = 9;
    localparam int COORD_W         = 8;
    localparam int CHAN_W          = 8;
    localparam int PIX_W           = 3 * CHAN_W;
    localparam int QUO_W           = DIM_W;
    localparam int NUM_W           = COORD_W + DIM_W;
    localparam int ADDR_W          = 2 * DIM_W;
    localparam int CFG_IDX_W       = 2;
    localparam int MAX_DIM_DEF     = 256;
    localparam int STORE_DEPTH_DEF = 65536;
    localparam int DIM_RESET_VAL   = 256;
    localparam int FIFO_DEPTH      = 16;
    localparam int FIFO_CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } cfg_reg_e;

    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } nnis_pix_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red_out;
        logic [CHAN_W-1:0] green_out;
        logic [CHAN_W-1:0] blue_out;
        logic              out_of_range;
    } nnis_res_t;

    // Sideband carried alongside the divider stages
    typedef struct packed {
        logic               mode;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [PIX_W-1:0]   rgb;
        logic               oor;
        logic               wok;
    } nnis_tag_t;

endpackage

`default_nettype wire

### rtl/nearest_neighbor_image_scaler_core.sv
// Top level of the nearest-neighbour image scaler.
//
//  channel | direction | handshake           | beat
//  --------+-----------+---------------------+----------------------------------
//  pix     | in        | pix_valid/pix_stall | nnis_pix_t: mode, x, y, rgb
//  res     | out       | res_valid/res_stall | nnis_res_t: rgb out, out_of_range
//  cfg     | in        | cfg_valid/cfg_ready | register index and 9-bit value
//
// One beat per cycle on pix while pix_stall is low; a read passes, in order, through:
// multiply, nine divider stages, address multiply, RAM read, result queue.
// Writes and reads reach the pixel RAM in order at one stage, so no forwarding.
// pix_stall rises once 16 reads are held in flight or in the result queue.
// Reset clears control only; pixel RAM is undefined until written, no clearing pass.
`default_nettype none

module nearest_neighbor_image_scaler_core #(
    parameter int MAX_DIM     = nnis_pkg::MAX_DIM_DEF,
    parameter int STORE_DEPTH = nnis_pkg::STORE_DEPTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           pix_valid,
    output logic                                pix_stall,
    input  wire nnis_pkg::nnis_pix_t            pix_data,
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output nnis_pkg::nnis_res_t                 res_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [nnis_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [nnis_pkg::DIM_W-1:0]     cfg_data
);
    import nnis_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int EW = (AW > ADDR_W) ? AW : ADDR_W;
    localparam logic [EW:0] DEPTH_LIM = (EW + 1)'(STORE_DEPTH);
    localparam logic [DIM_W-1:0] DIM_RESET =
        (MAX_DIM < DIM_RESET_VAL) ? DIM_W'(MAX_DIM) : DIM_W'(DIM_RESET_VAL);

    // configuration
    logic [DIM_W-1:0] sw_reg, sh_reg, dw_reg, dh_reg;
    logic [DIM_W-1:0] cfg_val;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_val = cfg_data;
        if (cfg_data > MAX_DIM)
        begin
            cfg_val = DIM_W'(MAX_DIM);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg <= DIM_RESET;
            sh_reg <= DIM_RESET;
            dw_reg <= DIM_RESET;
            dh_reg <= DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_e'(cfg_index))
                REG_SRC_WIDTH:  sw_reg <= cfg_val;
                REG_SRC_HEIGHT: sh_reg <= cfg_val;
                REG_DST_WIDTH:  dw_reg <= cfg_val;
                REG_DST_HEIGHT: dh_reg <= cfg_val;
                default:        ;
            endcase
        end
    end

    // credit for results in flight or queued
    logic                  pix_acc, res_acc;
    logic [FIFO_CNT_W-1:0] cred_reg, cred_next;

    assign pix_stall = (cred_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign pix_acc   = pix_valid && !pix_stall;
    assign res_acc   = res_valid && !res_stall;

    always_comb
    begin
        cred_next = cred_reg + FIFO_CNT_W'(pix_acc && (pix_data.mode == MODE_READ))
                  - FIFO_CNT_W'(res_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cred_reg <= '0;
        end
        else
        begin
            cred_reg <= cred_next;
        end
    end

    // stage A: range checks and scaling products
    nnis_tag_t        a_tag_next;
    nnis_tag_t        a_tag_reg;
    logic             a_v_reg;
    logic [NUM_W-1:0] prod_x_reg, prod_y_reg;

    always_comb
    begin
        a_tag_next.mode = pix_data.mode;
        a_tag_next.x    = pix_data.x;
        a_tag_next.y    = pix_data.y;
        a_tag_next.rgb  = {pix_data.red, pix_data.green, pix_data.blue};
        a_tag_next.oor  = (DIM_W'(pix_data.x) >= dw_reg) || (DIM_W'(pix_data.y) >= dh_reg);
        a_tag_next.wok  = (DIM_W'(pix_data.x) < sw_reg) && (DIM_W'(pix_data.y) < sh_reg);
    end

    always_ff @(posedge clk)
    begin
        a_tag_reg  <= a_tag_next;
        prod_x_reg <= NUM_W'(pix_data.x) * NUM_W'(sw_reg);
        prod_y_reg <= NUM_W'(pix_data.y) * NUM_W'(sh_reg);
    end

    // divider stages
    logic [QUO_W-1:0] quo_x, quo_y;
    nnis_tag_t        d_tag_reg [QUO_W];
    logic [QUO_W-1:0] d_v_reg;

    nnis_div_pipe u_div_x (
        .clk (clk),
        .num (prod_x_reg),
        .den (dw_reg),
        .quo (quo_x)
    );

    nnis_div_pipe u_div_y (
        .clk (clk),
        .num (prod_y_reg),
        .den (dh_reg),
        .quo (quo_y)
    );

    always_ff @(posedge clk)
    begin
        d_tag_reg[0] <= a_tag_reg;
        for (int i = 1; i < QUO_W; i++)
        begin
            d_tag_reg[i] <= d_tag_reg[i-1];
        end
    end

    // address stage
    nnis_tag_t         m_tag_reg;
    logic              m_v_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [QUO_W-1:0]  sx, sy;
    nnis_tag_t         d_last;

    assign d_last = d_tag_reg[QUO_W-1];

    always_comb
    begin
        sx = QUO_W'(d_last.x);
        sy = QUO_W'(d_last.y);
        if (d_last.mode == MODE_READ)
        begin
            sx = quo_x;
            sy = quo_y;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tag_reg <= d_last;
        addr_reg  <= ADDR_W'(sy) * ADDR_W'(sw_reg) + ADDR_W'(sx);
    end

    // RAM stage
    logic [EW:0]      addr_ext;
    logic             in_store;
    logic             ram_we, ram_re;
    logic [PIX_W-1:0] ram_rdata;
    logic             r_v_reg;
    logic             r_oor_reg, r_zero_reg;

    assign addr_ext = (EW + 1)'(addr_reg);
    assign in_store = (addr_ext < DEPTH_LIM);
    assign ram_we   = m_v_reg && (m_tag_reg.mode == MODE_WRITE) && m_tag_reg.wok && in_store;
    assign ram_re   = m_v_reg && (m_tag_reg.mode == MODE_READ) && !m_tag_reg.oor && in_store;

    nnis_ram #(
        .W     (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_ext[AW-1:0]),
        .wdata (m_tag_reg.rgb),
        .re    (ram_re),
        .raddr (addr_ext[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        r_oor_reg  <= m_tag_reg.oor;
        r_zero_reg <= m_tag_reg.oor || !in_store;
    end

    // valid bits of the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            d_v_reg <= '0;
            m_v_reg <= 1'b0;
            r_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= pix_acc;
            d_v_reg <= {d_v_reg[QUO_W-2:0], a_v_reg};
            m_v_reg <= d_v_reg[QUO_W-1];
            r_v_reg <= m_v_reg && (m_tag_reg.mode == MODE_READ);
        end
    end

    // result queue
    nnis_res_t push_data;

    always_comb
    begin
        push_data.red_out      = r_zero_reg ? '0 : ram_rdata[3*CHAN_W-1:2*CHAN_W];
        push_data.green_out    = r_zero_reg ? '0 : ram_rdata[2*CHAN_W-1:CHAN_W];
        push_data.blue_out     = r_zero_reg ? '0 : ram_rdata[CHAN_W-1:0];
        push_data.out_of_range = r_oor_reg;
    end

    nnis_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (r_v_reg),
        .push_data (push_data),
        .pop       (res_acc),
        .valid     (res_valid),
        .data      (res_data)
    );

endmodule

`default_nettype wire

### rtl/nnis_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module nnis_ram #(
    parameter int W     = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [W-1:0]             wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/nnis_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module nnis_div_pipe (
    input  wire logic                       clk,
    input  wire logic [nnis_pkg::NUM_W-1:0] num,
    input  wire logic [nnis_pkg::DIM_W-1:0] den,
    output logic      [nnis_pkg::QUO_W-1:0] quo
);
    import nnis_pkg::*;

    localparam int REM_W = NUM_W + 1;

    logic [REM_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];

    for (genvar s = 0; s < QUO_W; s++)
    begin : g_stage
        localparam int B = QUO_W - 1 - s;
        logic [REM_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [REM_W-1:0] dsh;
        logic [REM_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (s == 0)
        begin : g_first
            assign rem_in = REM_W'(num);
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        assign dsh = REM_W'(den) << B;

        always_comb
        begin
            rem_next = rem_in;
            quo_next = quo_in;
            if (rem_in >= dsh)
            begin
                rem_next = rem_in - dsh;
                quo_next = quo_in | (QUO_W'(1) << B);
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            quo_reg[s] <= quo_next;
        end
    end

    assign quo = quo_reg[QUO_W-1];

endmodule

`default_nettype wire

### rtl/nnis_out_fifo.sv
// Result queue that parts the pipeline from the result channel.
`default_nettype none

module nnis_out_fifo (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire nnis_pkg::nnis_res_t push_data,
    input  wire logic                pop,
    output logic                     valid,
    output nnis_pkg::nnis_res_t      data
);
    import nnis_pkg::*;

    localparam int PTR_W = $clog2(FIFO_DEPTH);

    nnis_res_t             buf_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]      wptr_reg, wptr_next;
    logic [PTR_W-1:0]      rptr_reg, rptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        wptr_next = push ? wptr_reg + PTR_W'(1) : wptr_reg;
        rptr_next = pop ? rptr_reg + PTR_W'(1) : rptr_reg;
        cnt_next  = cnt_reg + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wptr_reg] <= push_data;
        end
    end

    assign valid = (cnt_reg != '0);
    assign data  = buf_reg[rptr_reg];

endmodule

`default_nettype wire

### rtl/nnis_checker.sv
// Port-level checks of the scaler core, bound to the top level.
`default_nettype none

module nnis_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                pix_valid,
    input wire logic                pix_stall,
    input wire nnis_pkg::nnis_pix_t pix_data,
    input wire logic                res_valid,
    input wire logic                res_stall,
    input wire nnis_pkg::nnis_res_t res_data,
    input wire logic                cfg_valid,
    input wire logic                cfg_ready
);
    import nnis_pkg::*;

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.out_of_range |->
            (res_data.red_out == '0) && (res_data.green_out == '0) &&
            (res_data.blue_out == '0))
        else $error("out-of-range result carries pixel data");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pix_stall) |-> $past(pix_valid && !pix_stall && (pix_data.mode == MODE_READ)))
        else $error("input stall rose without a read beat");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration beat refused");

endmodule

bind nearest_neighbor_image_scaler_core nnis_checker u_nnis_checker (.*);

`default_nettype wire

### test/tb_nearest_neighbor_image_scaler_core.sv
// Self-checking testbench of the nearest-neighbour image scaler: pixel writes and scaled reads.
`timescale 1ns / 1ps

module tb_nearest_neighbor_image_scaler_core;

    import nnis_pkg::*;

    localparam int unsigned DEPTH = STORE_DEPTH_DEF;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 pix_valid  = 1'b0;
    logic                 pix_stall;
    nnis_pix_t            pix_data   = '0;
    logic                 res_valid;
    logic                 res_stall  = 1'b0;
    nnis_res_t            res_data;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    logic [DIM_W-1:0]     cfg_data   = '0;

    nearest_neighbor_image_scaler_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // scaling registers as the block should hold them
    int unsigned src_w = DIM_RESET_VAL;
    int unsigned src_h = DIM_RESET_VAL;
    int unsigned dst_w = DIM_RESET_VAL;
    int unsigned dst_h = DIM_RESET_VAL;

    logic [PIX_W-1:0] pixel_mem [DEPTH];
    bit               filled    [DEPTH];

    nnis_pix_t   pixel_beats[$];
    nnis_res_t   sampled_pixels[$];
    int unsigned beats_queued   = 0;
    int unsigned beats_accepted = 0;
    int unsigned counted        = 0;
    int unsigned mismatches     = 0;

    int burst_left = 1;
    int gap_left   = 0;
    int stall_mode = 0;
    int stall_left = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
        return (v > MAX_DIM_DEF) ? MAX_DIM_DEF : v;
    endfunction

    function automatic int unsigned source_col(input int unsigned x);
        return (x * src_w) / dst_w;
    endfunction

    function automatic int unsigned source_row(input int unsigned y);
        return (y * src_h) / dst_h;
    endfunction

    function automatic bit write_lands(input int unsigned x, input int unsigned y);
        return x < src_w && y < src_h && (y * src_w + x) < DEPTH;
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(input int unsigned lim);
        if (lim == 0 || $urandom_range(0, 7) == 0)
            return $urandom_range(0, 255);
        return $urandom_range(0, lim - 1);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(0, 19))
            0:       return '0;
            1, 2:    return 9'd1;
            3, 4:    return 9'd256;
            5:       return $urandom_range(257, 511);
            6, 7, 8: return $urandom_range(1, 8);
            default: return $urandom_range(1, 256);
        endcase
    endfunction

    function automatic void queue_write(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                                        input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                        input logic [CHAN_W-1:0] b);
        nnis_pix_t beat;
        beat = '{mode: MODE_WRITE, x: x, y: y, red: r, green: g, blue: b};
        pixel_beats.push_back(beat);
        beats_queued++;
        if (write_lands(x, y))
        begin
            filled[y * src_w + x] = 1'b1;
            counted++;
        end
    endfunction

    // A read of a pixel never written is kept out: the pixel is written first,
    // or the read is dropped when no write can reach it.
    function automatic bit queue_read(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        int unsigned sx;
        int unsigned sy;
        nnis_pix_t   beat;
        if (x < dst_w && y < dst_h)
        begin
            sx = source_col(x);
            sy = source_row(y);
            if (sy * src_w + sx < DEPTH && !filled[sy * src_w + sx])
            begin
                if (!write_lands(sx, sy))
                    return 1'b0;
                queue_write(sx, sy, $urandom_range(0, 255), $urandom_range(0, 255),
                            $urandom_range(0, 255));
            end
        end
        beat = '{mode: MODE_READ, x: x, y: y, red: $urandom_range(0, 255),
                 green: $urandom_range(0, 255), blue: $urandom_range(0, 255)};
        pixel_beats.push_back(beat);
        beats_queued++;
        counted++;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < 50)
            $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic predict_pixel(input nnis_pix_t beat);
        nnis_res_t   want;
        int unsigned a;
        if (beat.mode == MODE_WRITE)
        begin
            if (write_lands(beat.x, beat.y))
                pixel_mem[beat.y * src_w + beat.x] = {beat.red, beat.green, beat.blue};
        end
        else
        begin
            want = '0;
            if (beat.x >= dst_w || beat.y >= dst_h)
                want.out_of_range = 1'b1;
            else
            begin
                a = source_row(beat.y) * src_w + source_col(beat.x);
                if (a < DEPTH)
                    {want.red_out, want.green_out, want.blue_out} = pixel_mem[a];
            end
            sampled_pixels.push_back(want);
        end
    endtask

    task automatic check_pixel(input nnis_res_t got);
        nnis_res_t want;
        if (sampled_pixels.size() == 0)
        begin
            flag_mismatch($sformatf("result %h with none expected", got));
            return;
        end
        want = sampled_pixels.pop_front();
        if (got.red_out !== want.red_out)
            flag_mismatch($sformatf("red_out %h, expected %h", got.red_out, want.red_out));
        if (got.green_out !== want.green_out)
            flag_mismatch($sformatf("green_out %h, expected %h", got.green_out, want.green_out));
        if (got.blue_out !== want.blue_out)
            flag_mismatch($sformatf("blue_out %h, expected %h", got.blue_out, want.blue_out));
        if (got.out_of_range !== want.out_of_range)
            flag_mismatch($sformatf("out_of_range %b, expected %b",
                                    got.out_of_range, want.out_of_range));
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [DIM_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:  src_w = clamp_dim(val);
            REG_SRC_HEIGHT: src_h = clamp_dim(val);
            REG_DST_WIDTH:  dst_w = clamp_dim(val);
            REG_DST_HEIGHT: dst_h = clamp_dim(val);
        endcase
    endtask

    task automatic set_scale(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                             input logic [DIM_W-1:0] dw, input logic [DIM_W-1:0] dh);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
    endtask

    // all beats taken, all results back, then room for writes still in the pipe
    task automatic settle();
        while (beats_accepted != beats_queued)
            @(posedge clk);
        while (sampled_pixels.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic fill_phase(input int unsigned quota);
        int unsigned goal;
        int unsigned tries;
        goal  = counted + quota;
        tries = 0;
        while (counted < goal && tries < 4 * quota)
        begin
            tries++;
            if ($urandom_range(0, 9) < 4)
                queue_write(pick_coord(src_w), pick_coord(src_h), $urandom_range(0, 255),
                            $urandom_range(0, 255), $urandom_range(0, 255));
            else
                void'(queue_read(pick_coord(dst_w), pick_coord(dst_h)));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid  <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else if (!pix_valid || !pix_stall)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                pix_valid <= 1'b0;
            end
            else if (pixel_beats.size() != 0)
            begin
                pix_valid <= 1'b1;
                pix_data  <= pixel_beats.pop_front();
                burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                pix_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall  <= 1'b0;
            stall_mode = 0;
            stall_left = 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 96);
            end
            else
                stall_left--;
            case (stall_mode)
                0:       res_stall <= 1'b0;
                1:       res_stall <= ($urandom_range(0, 3) == 0);
                2:       res_stall <= ($urandom_range(0, 3) != 0);
                default: res_stall <= (stall_left % 24) < 18;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && !pix_stall)
            begin
                predict_pixel(pix_data);
                beats_accepted++;
            end
            if (res_valid && !res_stall)
                check_pixel(res_data);
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // identity scale at reset values, corners and channel extremes
        queue_write(8'd0, 8'd0, 8'hff, 8'h00, 8'hff);
        queue_write(8'd255, 8'd255, 8'h00, 8'hff, 8'h00);
        queue_write(8'd255, 8'd0, $urandom_range(0, 255), 8'h80, 8'h7f);
        queue_write(8'd0, 8'd255, 8'h01, $urandom_range(0, 255), 8'hfe);
        void'(queue_read(8'd0, 8'd0));
        void'(queue_read(8'd255, 8'd255));
        void'(queue_read(8'd255, 8'd0));
        void'(queue_read(8'd0, 8'd255));
        settle();

        // full frame down to one pixel
        set_scale(9'd256, 9'd256, 9'd1, 9'd1);
        void'(queue_read(8'd0, 8'd0));
        void'(queue_read(8'd1, 8'd0));
        void'(queue_read(8'd0, 8'd255));
        settle();

        // one pixel up to a full frame; write outside source ignored
        set_scale(9'd1, 9'd1, 9'd256, 9'd256);
        queue_write(8'd1, 8'd0, 8'haa, 8'h55, 8'hcc);
        queue_write(8'd0, 8'd0, 8'h3c, 8'hc3, 8'h99);
        void'(queue_read(8'd255, 8'd255));
        void'(queue_read(8'd128, 8'd7));
        settle();

        // oversize values saturate, zero destination makes every read out of range
        set_scale(9'd511, 9'd300, 9'd0, 9'd0);
        void'(queue_read(8'd0, 8'd0));
        queue_write(8'd3, 8'd3, 8'h11, 8'h22, 8'h33);
        settle();

        // zero source: writes ignored, reads collapse onto the first pixel
        set_scale(9'd0, 9'd0, 9'd2, 9'd2);
        queue_write(8'd0, 8'd0, 8'hee, 8'hdd, 8'hbb);
        void'(queue_read(8'd1, 8'd1));
        settle();

        while (counted < 1000)
        begin
            set_scale(pick_dim(), pick_dim(), pick_dim(), pick_dim());
            fill_phase(80);
            settle();
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
